[rtl/core/gvlf_pkg.sv]
// shared types and constants of the garch variance likelihood filter
`default_nettype none
package gvlf_pkg;

  localparam int FRAC_BITS = 16;
  localparam int COUNT_WIDTH_DEF = 20;
  localparam int ITER_W = $clog2(FRAC_BITS);
  localparam int SUM_W = 56;

  localparam logic [31:0] OMEGA_RST = 32'd65536;
  localparam logic [15:0] A_WEIGHT_RST = 16'd6554;
  localparam logic [15:0] B_WEIGHT_RST = 16'd58982;
  localparam logic [31:0] INIT_VAR_RST = 32'd65536;

  // ln 2 in q0.32, ln(2 pi) rounded to the fixed point format
  localparam logic [31:0] LN2_Q32 = 32'd2977044472;
  localparam logic [63:0] LN2PI_FX =
    (64'd7893621894 + (64'd1 << (31 - FRAC_BITS))) >> (32 - FRAC_BITS);
  localparam logic [45:0] E2_CAP = '1;

  typedef enum logic [1:0] {
    REG_OMEGA,
    REG_A_WEIGHT,
    REG_B_WEIGHT,
    REG_INIT_VAR
  } cfg_reg_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_NORM,
    ST_LOG,
    ST_LN2,
    ST_UPD0,
    ST_UPD1,
    ST_UPD2,
    ST_UPD3,
    ST_UPD4,
    ST_VAR,
    ST_TERM,
    ST_SUM,
    ST_MSTART,
    ST_MEAN,
    ST_DONE
  } state_e;

endpackage
`default_nettype wire

[rtl/core/gvlf_in_if.sv]
// sample channel interface
`default_nettype none
interface gvlf_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] sample;
  logic               is_last;

  modport source (output valid, output sample, output is_last, input ready);
  modport sink (input valid, input sample, input is_last, output ready);
endinterface
`default_nettype wire

[rtl/core/gvlf_out_if.sv]
// result channel interface
`default_nettype none
interface gvlf_out_if;
  logic               valid;
  logic               ready;
  logic        [31:0] variance;
  logic signed [31:0] lik_term;
  logic signed [31:0] mean_llik;
  logic               done_res;
  logic               invalid;

  modport source (output valid, output variance, output lik_term, output mean_llik,
                  output done_res, output invalid, input ready);
  modport sink (input valid, input variance, input lik_term, input mean_llik,
                input done_res, input invalid, output ready);
endinterface
`default_nettype wire

[rtl/core/gvlf_cfg_if.sv]
// configuration write channel interface
`default_nettype none
interface gvlf_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [31:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

[rtl/core/gvlf_div.sv]
// radix-4 restoring divider, 64 by 32 bits
`default_nettype none
module gvlf_div (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [63:0] dividend_i,
  input  wire logic [31:0] divisor_i,
  output logic             busy_o,
  output logic [63:0]      quotient_o
);

  logic        busy_q;
  logic [4:0]  cnt_q;
  logic [63:0] num_q;
  logic [31:0] rem_q;
  logic [31:0] den_q;

  logic [32:0] r1, r1s, r2, r2s;
  logic        ge1, ge2;

  always_comb begin
    r1  = {rem_q, num_q[63]};
    ge1 = r1 >= {1'b0, den_q};
    r1s = ge1 ? (r1 - {1'b0, den_q}) : r1;
    r2  = {r1s[31:0], num_q[62]};
    ge2 = r2 >= {1'b0, den_q};
    r2s = ge2 ? (r2 - {1'b0, den_q}) : r2;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 5'd1;
      if (cnt_q == 5'd31) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= dividend_i;
      rem_q <= '0;
      den_q <= divisor_i;
    end else if (busy_q) begin
      num_q <= {num_q[61:0], ge1, ge2};
      rem_q <= r2s[31:0];
    end
  end

  assign busy_o     = busy_q;
  assign quotient_o = num_q;

endmodule
`default_nettype wire

[rtl/core/garch_variance_likelihood_filter.sv]
// GARCH(1,1) variance filter with gaussian log-likelihood, top level
// Usage:
//  - in_i carries one signed q16.16 return sample per transfer, with is_last
//    marking the final sample of a series; out_o gives one result per sample
//  - cfg_i writes omega, a_weight, b_weight and initial_variance by index;
//    it is always ready; the user must write it only while the block is idle,
//    as the block itself does not enforce this
//  - each sample runs one square, a 16-step log by repeated squaring on the
//    shared multiplier and five multiply-accumulate steps of the variance
//    update, all overlapped with the radix-4 divider for e^2/f, whose end
//    sets when the result is ready
//  - a zero variance skips the log and the divider
//  - for a last sample of a valid series the same divider then forms its mean
//  - in_i is ready only when no sample is in work; the result waits in an
//    output register, so a new sample is taken while it is not yet collected
//  - a stalled receiver holds the result and, once the next sample is done,
//    holds the block until the pending transfer completes
//  - reset restores the register defaults and starts a fresh series
`default_nettype none
module garch_variance_likelihood_filter #(
  parameter int COUNT_WIDTH = gvlf_pkg::COUNT_WIDTH_DEF
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  gvlf_in_if.sink   in_i,
  gvlf_out_if.source out_o,
  gvlf_cfg_if.sink  cfg_i
);

  localparam int F = gvlf_pkg::FRAC_BITS;
  localparam int SW = gvlf_pkg::SUM_W;

  gvlf_pkg::state_e state_q, state_d;

  logic [31:0] omega_q, init_var_q;
  logic [15:0] a_q, b_q;

  logic [31:0]            cur_var_q;
  logic signed [SW-1:0]   sum_q;
  logic [COUNT_WIDTH-1:0] count_q;
  logic                   bad_q;

  logic [31:0]             mag_q, f_q;
  logic                    last_q;
  logic [63:0]             e2_q;
  logic [31:0]             m_q;
  logic [4:0]              msb_q;
  logic [F-1:0]            frac_q;
  logic [gvlf_pkg::ITER_W-1:0] iter_q;
  logic [63:0]             lnp_q;
  logic                    lnneg_q;
  logic signed [31:0]      ln_q;
  logic signed [63:0]      acc_q;
  logic signed [31:0]      term_q, mean_q;

  logic               out_valid_q, out_done_q, out_bad_q;
  logic [31:0]        out_var_q;
  logic signed [31:0] out_term_q, out_mean_q;

  logic [32:0] mul_a, mul_b;
  logic [65:0] mul_p;
  logic        div_start, div_busy;
  logic [63:0] div_dividend, div_q;
  logic [31:0] div_divisor;
  logic        in_ready, out_load;

  // combinational helpers
  logic [4:0]         msb;
  logic [32:0]        sq;
  logic signed [31:0] l2, l2mag;
  logic [63:0]        e2sh;
  logic [45:0]        e2q;
  logic [31:0]        lnr;
  logic signed [63:0] tsum, thalf, tneg, tsat;
  logic signed [SW:0] s_ext;
  logic [SW:0]        sum_abs;
  logic signed [63:0] mneg, msat;
  logic [31:0]        nf;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      omega_q    <= gvlf_pkg::OMEGA_RST;
      a_q        <= gvlf_pkg::A_WEIGHT_RST;
      b_q        <= gvlf_pkg::B_WEIGHT_RST;
      init_var_q <= gvlf_pkg::INIT_VAR_RST;
    end else if (cfg_i.valid) begin
      case (gvlf_pkg::cfg_reg_e'(cfg_i.index))
        gvlf_pkg::REG_OMEGA:    omega_q    <= cfg_i.data;
        gvlf_pkg::REG_A_WEIGHT: a_q        <= cfg_i.data[15:0];
        gvlf_pkg::REG_B_WEIGHT: b_q        <= cfg_i.data[15:0];
        gvlf_pkg::REG_INIT_VAR: init_var_q <= cfg_i.data;
        default: ;
      endcase
    end
  end

  always_comb begin
    msb = '0;
    for (int i = 0; i < 32; i++) begin
      if (f_q[i]) begin
        msb = 5'(i);
      end
    end
    sq      = mul_p[63:31];
    l2      = $signed(((32'(msb_q) - 32'(F)) << F) + 32'(frac_q));
    l2mag   = l2[31] ? -l2 : l2;
    e2sh    = e2_q >> F;
    e2q     = (e2sh > 64'(gvlf_pkg::E2_CAP)) ? gvlf_pkg::E2_CAP : e2sh[45:0];
    lnr     = 32'((lnp_q + 64'h8000_0000) >> 32);
    tsum    = 64'(ln_q) + $signed(div_q) + $signed(gvlf_pkg::LN2PI_FX);
    thalf   = tsum[63] ? ((tsum + 64'sd1) >>> 1) : (tsum >>> 1);
    tneg    = -thalf;
    if (tneg > 64'sd2147483647) begin
      tsat = 64'sd2147483647;
    end else if (tneg < -64'sd2147483648) begin
      tsat = -64'sd2147483648;
    end else begin
      tsat = tneg;
    end
    s_ext   = {sum_q[SW-1], sum_q} + (SW+1)'(term_q);
    sum_abs = sum_q[SW-1] ? (-{sum_q[SW-1], sum_q}) : {1'b0, sum_q};
    mneg    = sum_q[SW-1] ? -$signed(div_q) : $signed(div_q);
    if (mneg > 64'sd2147483647) begin
      msat = 64'sd2147483647;
    end else if (mneg < -64'sd2147483648) begin
      msat = -64'sd2147483648;
    end else begin
      msat = mneg;
    end
    if (acc_q <= 64'sd0) begin
      nf = '0;
    end else if ((acc_q >>> 16) > 64'sd4294967295) begin
      nf = '1;
    end else begin
      nf = acc_q[47:16];
    end
  end

  assign mul_p = mul_a * mul_b;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      gvlf_pkg::ST_IDLE:   if (in_i.valid) state_d = gvlf_pkg::ST_SQUARE;
      gvlf_pkg::ST_SQUARE: state_d = gvlf_pkg::ST_NORM;
      gvlf_pkg::ST_NORM: begin
        state_d = (f_q == '0) ? gvlf_pkg::ST_UPD0 : gvlf_pkg::ST_LOG;
      end
      gvlf_pkg::ST_LOG: begin
        if (iter_q == gvlf_pkg::ITER_W'(F - 1)) state_d = gvlf_pkg::ST_LN2;
      end
      gvlf_pkg::ST_LN2:  state_d = gvlf_pkg::ST_UPD0;
      gvlf_pkg::ST_UPD0: state_d = gvlf_pkg::ST_UPD1;
      gvlf_pkg::ST_UPD1: state_d = gvlf_pkg::ST_UPD2;
      gvlf_pkg::ST_UPD2: state_d = gvlf_pkg::ST_UPD3;
      gvlf_pkg::ST_UPD3: state_d = gvlf_pkg::ST_UPD4;
      gvlf_pkg::ST_UPD4: state_d = gvlf_pkg::ST_VAR;
      gvlf_pkg::ST_VAR:  if (!div_busy) state_d = gvlf_pkg::ST_TERM;
      gvlf_pkg::ST_TERM: state_d = gvlf_pkg::ST_SUM;
      gvlf_pkg::ST_SUM: begin
        state_d = (last_q && !bad_q) ? gvlf_pkg::ST_MSTART : gvlf_pkg::ST_DONE;
      end
      gvlf_pkg::ST_MSTART: state_d = gvlf_pkg::ST_MEAN;
      gvlf_pkg::ST_MEAN:   if (!div_busy) state_d = gvlf_pkg::ST_DONE;
      gvlf_pkg::ST_DONE:   if (!out_valid_q || out_o.ready) state_d = gvlf_pkg::ST_IDLE;
      default:             state_d = gvlf_pkg::ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    mul_a        = '0;
    mul_b        = '0;
    div_start    = 1'b0;
    div_dividend = e2_q;
    div_divisor  = f_q;
    in_ready     = 1'b0;
    out_load     = 1'b0;
    case (state_q)
      gvlf_pkg::ST_IDLE:   in_ready = 1'b1;
      gvlf_pkg::ST_SQUARE: begin
        mul_a = {1'b0, mag_q};
        mul_b = {1'b0, mag_q};
      end
      gvlf_pkg::ST_NORM:   div_start = (f_q != '0);
      gvlf_pkg::ST_LOG: begin
        mul_a = {1'b0, m_q};
        mul_b = {1'b0, m_q};
      end
      gvlf_pkg::ST_LN2: begin
        mul_a = {1'b0, l2mag};
        mul_b = {1'b0, gvlf_pkg::LN2_Q32};
      end
      gvlf_pkg::ST_UPD0: begin
        mul_a = 33'(17'h10000 - {1'b0, b_q});
        mul_b = {1'b0, omega_q};
      end
      gvlf_pkg::ST_UPD1: begin
        mul_a = 33'(b_q);
        mul_b = {1'b0, f_q};
      end
      gvlf_pkg::ST_UPD2: begin
        mul_a = 33'(a_q);
        mul_b = {1'b0, e2q[31:0]};
      end
      gvlf_pkg::ST_UPD3: begin
        mul_a = 33'(a_q);
        mul_b = 33'(e2q[45:32]);
      end
      gvlf_pkg::ST_UPD4: begin
        mul_a = 33'(a_q);
        mul_b = {1'b0, f_q};
      end
      gvlf_pkg::ST_MSTART: begin
        div_start    = 1'b1;
        div_dividend = 64'(sum_abs);
        div_divisor  = 32'(count_q);
      end
      gvlf_pkg::ST_DONE:   out_load = !out_valid_q || out_o.ready;
      default: ;
    endcase
  end

  assign in_i.ready = in_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= gvlf_pkg::ST_IDLE;
      count_q     <= '0;
      bad_q       <= 1'b0;
      sum_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == gvlf_pkg::ST_TERM) begin
        if (count_q != '1) count_q <= count_q + 1'b1;
        if (f_q == '0) bad_q <= 1'b1;
      end
      if (state_q == gvlf_pkg::ST_SUM) begin
        if (s_ext[SW] != s_ext[SW-1]) begin
          sum_q <= s_ext[SW] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}};
        end else begin
          sum_q <= s_ext[SW-1:0];
        end
      end
      if (out_load && last_q) begin
        count_q <= '0;
        bad_q   <= 1'b0;
        sum_q   <= '0;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      gvlf_pkg::ST_IDLE: begin
        mag_q  <= in_i.sample[31] ? 32'(-in_i.sample) : 32'(in_i.sample);
        last_q <= in_i.is_last;
        f_q    <= (count_q == '0) ? init_var_q : cur_var_q;
      end
      gvlf_pkg::ST_SQUARE: e2_q <= mul_p[63:0];
      gvlf_pkg::ST_NORM: begin
        msb_q  <= msb;
        m_q    <= f_q << (5'd31 - msb);
        frac_q <= '0;
        iter_q <= '0;
      end
      gvlf_pkg::ST_LOG: begin
        iter_q <= iter_q + 1'b1;
        if (sq[32]) begin
          m_q    <= sq[32:1];
          frac_q <= {frac_q[F-2:0], 1'b1};
        end else begin
          m_q    <= sq[31:0];
          frac_q <= {frac_q[F-2:0], 1'b0};
        end
      end
      gvlf_pkg::ST_LN2: begin
        lnp_q   <= mul_p[63:0];
        lnneg_q <= l2[31];
      end
      gvlf_pkg::ST_UPD0: begin
        ln_q  <= lnneg_q ? -$signed(lnr) : $signed(lnr);
        acc_q <= $signed(mul_p[63:0]);
      end
      gvlf_pkg::ST_UPD1: acc_q <= acc_q + $signed(mul_p[63:0]);
      gvlf_pkg::ST_UPD2: acc_q <= acc_q + $signed(mul_p[63:0]);
      gvlf_pkg::ST_UPD3: acc_q <= acc_q + $signed({mul_p[31:0], 32'd0});
      gvlf_pkg::ST_UPD4: acc_q <= acc_q - $signed(mul_p[63:0]);
      gvlf_pkg::ST_VAR:  cur_var_q <= nf;
      gvlf_pkg::ST_TERM: term_q <= (f_q == '0) ? 32'sd0 : tsat[31:0];
      gvlf_pkg::ST_SUM:  mean_q <= (last_q && bad_q) ? {1'b1, 31'd0} : 32'sd0;
      gvlf_pkg::ST_MEAN: mean_q <= msat[31:0];
      gvlf_pkg::ST_DONE: begin
        if (out_load) begin
          out_var_q  <= f_q;
          out_term_q <= term_q;
          out_mean_q <= mean_q;
          out_done_q <= last_q;
          out_bad_q  <= bad_q;
        end
      end
      default: ;
    endcase
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.variance  = out_var_q;
  assign out_o.lik_term  = out_term_q;
  assign out_o.mean_llik = out_mean_q;
  assign out_o.done_res  = out_done_q;
  assign out_o.invalid   = out_bad_q;

  gvlf_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .busy_o     (div_busy),
    .quotient_o (div_q)
  );

  a_div_idle_on_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> !div_busy)
    else $error("divider started while busy");

  a_zero_var_term: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_var_q == '0) |-> out_term_q == 32'sd0)
    else $error("zero variance gave a nonzero term");

  a_bad_mean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_done_q && out_bad_q) |-> out_mean_q == {1'b1, 31'd0})
    else $error("invalid series without most negative mean");

  a_series_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && last_q) |=> (count_q == '0 && !bad_q && sum_q == '0))
    else $error("series state not cleared after last sample");

endmodule
`default_nettype wire
